@@ design/frna_pkg.sv @@
// Shared constants, types and codes for the fixed-radius neighbour average block.
package frna_pkg;

	// Default sizing handed to the top level
	localparam int DEF_MAX_AGENTS  = 64;
	localparam int DEF_COORD_WIDTH = 16;

	// Fixed field widths on the ports
	localparam int FIELD_W    = 16;
	localparam int INDEX_W    = 6;
	localparam int COUNT_W    = 6;
	localparam int RADIUS_W   = 16;
	localparam int AGENTS_W   = 7;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int PAYLOAD_W  = INDEX_W + 4 * FIELD_W;
	localparam int TDATA_W    = ((PAYLOAD_W + 7) / 8) * 8;
	localparam int PAD_W      = TDATA_W - PAYLOAD_W;
	localparam int R2_W       = 2 * RADIUS_W;
	localparam int COUNT_MAX  = (1 << COUNT_W) - 1;

	// Operation codes carried on tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_AGENT_COUNT = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QLOAD,
		ST_WALK,
		ST_DRAIN,
		ST_DIV,
		ST_OUT
	} frna_state_t;

	// Per-cycle control from the sequencer to the walk datapath
	typedef struct packed {
		logic clear;
		logic issue;
		logic skip;
	} frna_walk_ctl_t;

endpackage

@@ design/frna_table.sv @@
// Agent table: one synchronous memory, one write port and one registered read port.
module frna_table #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Store one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry, data valid the cycle after
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/frna_accum.sv @@
// Walk datapath: distance, radius test and neighbour sums over three stages.
module frna_accum #(
	parameter int CW = 16,
	parameter int NW = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  frna_pkg::frna_walk_ctl_t    ctl,
	input  logic [4*CW-1:0]             entry,
	input  logic signed [CW-1:0]        qx,
	input  logic signed [CW-1:0]        qy,
	input  logic [frna_pkg::R2_W-1:0]   r2,
	output logic                        busy,
	output logic [NW-1:0]               n,
	output logic signed [CW+NW-1:0]     sum_px,
	output logic signed [CW+NW-1:0]     sum_py,
	output logic signed [CW+NW-1:0]     sum_vx,
	output logic signed [CW+NW-1:0]     sum_vy
);

	localparam int SW   = CW + NW;
	localparam int D2W  = 2 * CW + 1;
	localparam int CMPW = (D2W > frna_pkg::R2_W) ? D2W : frna_pkg::R2_W;

	logic                 v_s1, skip_s1;
	logic                 v_s2, v_s3;
	logic [CW-1:0]        adx_s2, ady_s2;
	logic [4*CW-1:0]      entry_s2, entry_s3;
	logic [2*CW-1:0]      sqx_s3, sqy_s3;
	logic signed [CW:0]   dx, dy;
	logic [CW-1:0]        adx, ady;
	logic [D2W-1:0]       d2;
	logic                 hit;
	logic signed [CW-1:0] ex, ey, evx, evy;
	logic [NW-1:0]        n_q;
	logic signed [SW-1:0] spx_q, spy_q, svx_q, svy_q;

	// Tag the read issued last cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			skip_s1 <= 1'b0;
		end else begin
			v_s1    <= ctl.issue;
			skip_s1 <= ctl.skip;
		end
	end

	// Absolute coordinate differences to the queried agent
	assign dx  = $signed({entry[CW-1], entry[CW-1:0]}) - $signed({qx[CW-1], qx});
	assign dy  = $signed({entry[2*CW-1], entry[2*CW-1:CW]}) - $signed({qy[CW-1], qy});
	assign adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
	assign ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && !skip_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage two and three payload
	always_ff @(posedge clk) begin
		adx_s2   <= adx;
		ady_s2   <= ady;
		entry_s2 <= entry;
		sqx_s3   <= adx_s2 * adx_s2;
		sqy_s3   <= ady_s2 * ady_s2;
		entry_s3 <= entry_s2;
	end

	// Radius test on the exact squared distance
	assign d2  = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign hit = v_s3 && (CMPW'(d2) < CMPW'(r2));

	assign ex  = entry_s3[CW-1:0];
	assign ey  = entry_s3[2*CW-1:CW];
	assign evx = entry_s3[3*CW-1:2*CW];
	assign evy = entry_s3[4*CW-1:3*CW];

	// Count and sum the neighbours
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			spx_q <= '0;
			spy_q <= '0;
			svx_q <= '0;
			svy_q <= '0;
		end else if (ctl.clear) begin
			n_q   <= '0;
			spx_q <= '0;
			spy_q <= '0;
			svx_q <= '0;
			svy_q <= '0;
		end else if (hit) begin
			n_q   <= n_q + 1'b1;
			spx_q <= spx_q + SW'(ex);
			spy_q <= spy_q + SW'(ey);
			svx_q <= svx_q + SW'(evx);
			svy_q <= svy_q + SW'(evy);
		end
	end

	assign busy   = v_s1 || v_s2 || v_s3;
	assign n      = n_q;
	assign sum_px = spx_q;
	assign sum_py = spy_q;
	assign sum_vx = svx_q;
	assign sum_vy = svy_q;

endmodule

@@ design/frna_div.sv @@
// One lane of the mean divider: signed sum over unsigned count, one quotient bit a cycle.
module frna_div #(
	parameter int CW = 16,
	parameter int NW = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [CW+NW-1:0]  dividend,
	input  logic [NW-1:0]            divisor,
	output logic                     done,
	output logic signed [CW:0]       quot
);

	localparam int SW  = CW + NW;
	localparam int CTW = $clog2(CW + 1);

	logic           busy_q, done_q, neg_q;
	logic [CTW-1:0] cnt_q;
	logic [NW-1:0]  rem_q;
	logic [CW-1:0]  mq_q;
	logic [SW-1:0]  mag;
	logic [NW:0]    trial;
	logic           ge;

	// The mean never exceeds one stored value, so the upper dividend bits
	// are already a valid partial remainder and only CW steps remain.
	assign mag   = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
	assign trial = {rem_q, mq_q[CW-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CTW'(CW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Restoring shift-subtract step
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SW-1];
			rem_q <= mag[SW-1:CW];
			mq_q  <= mag[CW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? NW'(trial - {1'b0, divisor}) : NW'(trial);
			mq_q  <= {mq_q[CW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, mq_q}) : $signed({1'b0, mq_q});

endmodule

@@ design/fixed_radius_neighbor_average.sv @@
// Top level: agent table, query sequencer, walk datapath, mean dividers and output register.
//
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tuser: op; tdata: agent_index, pos_x, pos_y, vel_x, vel_y
// m_*       out  tvalid/tready      tdata: neighbor_count, avg_pos_x/y, avg_vel_x/y
// cfg_*     in   cfg_valid/ready    cfg_index: register, cfg_data: value
//
// A write word is stored from the idle state, which it does not leave. A query reads the queried
// entry, then makes one table read per entry in use through the single read port, drains the distance
// pipeline, then runs COORD_WIDTH steps of the four parallel divider lanes if it found a neighbour.
// Items are handled one at a time; the next word is taken while a result waits in m_tdata.
// Reset clears the configuration, control and sum registers and the sequencer; the table contents stay undefined.
module fixed_radius_neighbor_average #(
	parameter int MAX_AGENTS  = frna_pkg::DEF_MAX_AGENTS,
	parameter int COORD_WIDTH = frna_pkg::DEF_COORD_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [5:0] agent_index, [21:6] pos_x, [37:22] pos_y, [53:38] vel_x, [69:54] vel_y, rest 0
	input  logic [frna_pkg::TDATA_W-1:0]      s_tdata,
	// [0] op
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [5:0] neighbor_count, [21:6] avg_pos_x, [37:22] avg_pos_y,
	// [53:38] avg_vel_x, [69:54] avg_vel_y, rest 0
	output logic [frna_pkg::TDATA_W-1:0]      m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [frna_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [frna_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW = COORD_WIDTH;
	localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
	localparam int IW = $clog2(MAX_AGENTS + 1);
	localparam int NW = IW;
	localparam int SW = CW + NW;
	localparam int QW = CW + 1;
	localparam int FW = frna_pkg::FIELD_W;
	localparam int XW = frna_pkg::INDEX_W;

	frna_pkg::frna_state_t    state_q, state_d;
	frna_pkg::frna_walk_ctl_t walk_ctl;

	logic [frna_pkg::RADIUS_W-1:0] radius_q;
	logic [frna_pkg::AGENTS_W-1:0] agent_count_q;
	logic [frna_pkg::R2_W-1:0]     r2_q;
	logic [XW-1:0]                 idx_q;
	logic                          qvalid_q;
	logic [IW-1:0]                 i_q, used;
	logic signed [CW-1:0]          qx_q, qy_q;
	logic                          m_tvalid_q;
	logic [frna_pkg::TDATA_W-1:0]  m_tdata_q;

	logic                    in_op;
	logic [XW-1:0]           in_index;
	logic signed [FW-1:0]    in_pos_x, in_pos_y, in_vel_x, in_vel_y;
	logic                    in_idx_ok, accept, walk_more, out_free;
	logic                    mem_we, mem_re, div_start, out_load;
	logic [AW-1:0]           mem_raddr;
	logic [4*CW-1:0]         mem_wdata, mem_rdata;

	logic                    acc_busy;
	logic [NW-1:0]           acc_n;
	logic signed [SW-1:0]    acc_sum [4];
	logic                    lane_done [4];
	logic signed [QW-1:0]    lane_quot [4];
	logic [FW-1:0]           avg [4];
	logic                    div_done;
	logic [frna_pkg::COUNT_W-1:0] count_sat;

	// Unpack the input word
	assign in_op     = s_tuser[0];
	assign in_index  = s_tdata[XW-1:0];
	assign in_pos_x  = s_tdata[XW+FW-1:XW];
	assign in_pos_y  = s_tdata[XW+2*FW-1:XW+FW];
	assign in_vel_x  = s_tdata[XW+3*FW-1:XW+2*FW];
	assign in_vel_y  = s_tdata[XW+4*FW-1:XW+3*FW];
	assign in_idx_ok = 32'(in_index) < MAX_AGENTS;
	assign accept    = s_tvalid && s_tready;
	assign mem_wdata = {CW'(in_vel_y), CW'(in_vel_x), CW'(in_pos_y), CW'(in_pos_x)};

	assign used      = (32'(agent_count_q) > MAX_AGENTS) ? IW'(MAX_AGENTS) : IW'(agent_count_q);
	assign walk_more = i_q < used;
	assign out_free  = !m_tvalid_q || m_tready;
	assign div_done  = lane_done[0] && lane_done[1] && lane_done[2] && lane_done[3];

	// Configuration registers; the square of the radius is registered from them and follows in the next cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= '0;
			agent_count_q <= '0;
			r2_q          <= '0;
		end else begin
			r2_q <= {{frna_pkg::RADIUS_W{1'b0}}, radius_q} * {{frna_pkg::RADIUS_W{1'b0}}, radius_q};
			if (cfg_valid) begin
				unique case (cfg_index)
					frna_pkg::REG_RADIUS: begin
						radius_q <= cfg_data[frna_pkg::RADIUS_W-1:0];
					end
					frna_pkg::REG_AGENT_COUNT: begin
						agent_count_q <= cfg_data[frna_pkg::AGENTS_W-1:0];
					end
				endcase
			end
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frna_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, table access and unit strobes
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = i_q[AW-1:0];
		walk_ctl  = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			frna_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_op == frna_pkg::OP_QUERY) begin
						walk_ctl.clear = 1'b1;
						mem_re         = in_idx_ok;
						mem_raddr      = AW'(in_index);
						state_d        = frna_pkg::ST_QLOAD;
					end else begin
						mem_we = in_idx_ok;
					end
				end
			end
			frna_pkg::ST_QLOAD: begin
				if (walk_more) begin
					mem_re         = 1'b1;
					walk_ctl.issue = 1'b1;
					walk_ctl.skip  = qvalid_q && (32'(i_q) == 32'(idx_q));
				end
				state_d = frna_pkg::ST_WALK;
			end
			frna_pkg::ST_WALK: begin
				if (walk_more) begin
					mem_re         = 1'b1;
					walk_ctl.issue = 1'b1;
					walk_ctl.skip  = qvalid_q && (32'(i_q) == 32'(idx_q));
				end else begin
					state_d = frna_pkg::ST_DRAIN;
				end
			end
			frna_pkg::ST_DRAIN: begin
				if (!acc_busy) begin
					if (acc_n != '0) begin
						div_start = 1'b1;
						state_d   = frna_pkg::ST_DIV;
					end else begin
						state_d = frna_pkg::ST_OUT;
					end
				end
			end
			frna_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = frna_pkg::ST_OUT;
				end
			end
			frna_pkg::ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = frna_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = frna_pkg::ST_IDLE;
			end
		endcase
	end

	// Query context: index, walk counter and queried position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qvalid_q <= 1'b0;
			i_q      <= '0;
		end else begin
			if (accept && in_op == frna_pkg::OP_QUERY) begin
				qvalid_q <= in_idx_ok;
				i_q      <= '0;
			end else if (walk_ctl.issue) begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= in_index;
		end
		if (state_q == frna_pkg::ST_QLOAD) begin
			qx_q <= qvalid_q ? $signed(mem_rdata[CW-1:0]) : '0;
			qy_q <= qvalid_q ? $signed(mem_rdata[2*CW-1:CW]) : '0;
		end
	end

	frna_table #(
		.DEPTH (MAX_AGENTS),
		.WIDTH (4 * CW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(in_index)),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	frna_accum #(
		.CW (CW),
		.NW (NW)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (walk_ctl),
		.entry  (mem_rdata),
		.qx     (qx_q),
		.qy     (qy_q),
		.r2     (r2_q),
		.busy   (acc_busy),
		.n      (acc_n),
		.sum_px (acc_sum[0]),
		.sum_py (acc_sum[1]),
		.sum_vx (acc_sum[2]),
		.sum_vy (acc_sum[3])
	);

	// Four divider lanes share the count and run side by side
	for (genvar g = 0; g < 4; g++) begin : g_lane
		frna_div #(
			.CW (CW),
			.NW (NW)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.dividend (acc_sum[g]),
			.divisor  (acc_n),
			.done     (lane_done[g]),
			.quot     (lane_quot[g])
		);

		// Fit the quotient to the 16-bit result field
		if (QW >= FW) begin : g_trunc
			assign avg[g] = (acc_n == '0) ? '0 : lane_quot[g][FW-1:0];
		end else begin : g_sext
			assign avg[g] = (acc_n == '0) ? '0 : {{(FW-QW){lane_quot[g][QW-1]}}, lane_quot[g]};
		end
	end

	assign count_sat = (32'(acc_n) > frna_pkg::COUNT_MAX) ?
		frna_pkg::COUNT_W'(frna_pkg::COUNT_MAX) : frna_pkg::COUNT_W'(acc_n);

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {{frna_pkg::PAD_W{1'b0}}, avg[3], avg[2], avg[1], avg[0], count_sat};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A query word always moves on to loading the queried position
	a_query_load: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_op == frna_pkg::OP_QUERY) |=> (state_q == frna_pkg::ST_QLOAD))
		else $error("query accepted without position load");

	// The walk counter starts from the first entry
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == frna_pkg::ST_QLOAD) |-> (i_q == '0))
		else $error("walk counter not cleared at query start");

	// Reads in flight only while walking or draining
	a_busy_walk: assert property (@(posedge clk) disable iff (!arst_n)
		acc_busy |-> (state_q == frna_pkg::ST_WALK || state_q == frna_pkg::ST_DRAIN))
		else $error("distance pipeline busy outside the walk");

	// Divider completion only seen while waiting for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == frna_pkg::ST_DIV))
		else $error("divider finished outside the divide state");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the neighbour average block: table writes, radius queries, random pacing.
`timescale 1ns / 1ps

module testbench;

	localparam int ITEM_TARGET   = 1200;
	localparam int SETTLE_CYCLES = 120;
	localparam int TABLE_SIZE    = frna_pkg::DEF_MAX_AGENTS;

	typedef struct {
		logic [frna_pkg::COUNT_W-1:0]        count;
		logic signed [frna_pkg::FIELD_W-1:0] pos_x;
		logic signed [frna_pkg::FIELD_W-1:0] pos_y;
		logic signed [frna_pkg::FIELD_W-1:0] vel_x;
		logic signed [frna_pkg::FIELD_W-1:0] vel_y;
	} hood_mean_t;

	// Mirror of the agent table and registers; predicts each query result
	class neighbor_scoreboard;
		logic signed [frna_pkg::FIELD_W-1:0] pos_x [TABLE_SIZE];
		logic signed [frna_pkg::FIELD_W-1:0] pos_y [TABLE_SIZE];
		logic signed [frna_pkg::FIELD_W-1:0] vel_x [TABLE_SIZE];
		logic signed [frna_pkg::FIELD_W-1:0] vel_y [TABLE_SIZE];
		logic [frna_pkg::RADIUS_W-1:0]       radius;
		logic [frna_pkg::AGENTS_W-1:0]       agents;
		hood_mean_t                          awaited [$];
		int unsigned                         mismatches;
		int unsigned                         results;
		int unsigned                         empty_hoods;
		int unsigned                         widest;

		function new();
			radius      = '0;
			agents      = '0;
			mismatches  = 0;
			results     = 0;
			empty_hoods = 0;
			widest      = 0;
		endfunction

		function void fault(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", what);
		endfunction

		function void set_register(logic [frna_pkg::CFG_IDX_W-1:0] idx,
			logic [frna_pkg::CFG_DATA_W-1:0] value);
			case (idx)
				frna_pkg::REG_RADIUS:      radius = value;
				frna_pkg::REG_AGENT_COUNT: agents = value[frna_pkg::AGENTS_W-1:0];
				default: ;
			endcase
		endfunction

		// Walk the entries in use and average those, other than the centre, strictly inside the radius
		function hood_mean_t neighbourhood_mean(int unsigned centre);
			hood_mean_t  m;
			longint      cx, cy, dx, dy, r2;
			longint      sum_px, sum_py, sum_vx, sum_vy;
			int unsigned found, span;
			cx = pos_x[centre];
			cy = pos_y[centre];
			span = (agents > TABLE_SIZE) ? TABLE_SIZE : agents;
			r2 = longint'(radius) * longint'(radius);
			found = 0;
			sum_px = 0;
			sum_py = 0;
			sum_vx = 0;
			sum_vy = 0;
			for (int unsigned i = 0; i < span; i++) begin
				if (i == centre)
					continue;
				dx = pos_x[i] - cx;
				dy = pos_y[i] - cy;
				if (dx * dx + dy * dy < r2) begin
					found++;
					sum_px += pos_x[i];
					sum_py += pos_y[i];
					sum_vx += vel_x[i];
					sum_vy += vel_y[i];
				end
			end
			m.count = frna_pkg::COUNT_W'((found > frna_pkg::COUNT_MAX) ?
				frna_pkg::COUNT_MAX : found);
			m.pos_x = found ? 16'(sum_px / longint'(found)) : '0;
			m.pos_y = found ? 16'(sum_py / longint'(found)) : '0;
			m.vel_x = found ? 16'(sum_vx / longint'(found)) : '0;
			m.vel_y = found ? 16'(sum_vy / longint'(found)) : '0;
			return m;
		endfunction

		function void note_word(logic op, logic [frna_pkg::INDEX_W-1:0] idx,
			logic signed [frna_pkg::FIELD_W-1:0] wx, logic signed [frna_pkg::FIELD_W-1:0] wy,
			logic signed [frna_pkg::FIELD_W-1:0] ux, logic signed [frna_pkg::FIELD_W-1:0] uy);
			if (op == frna_pkg::OP_WRITE) begin
				pos_x[idx] = wx;
				pos_y[idx] = wy;
				vel_x[idx] = ux;
				vel_y[idx] = uy;
			end else begin
				awaited.push_back(neighbourhood_mean(idx));
			end
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
			if (seen !== want)
				fault($sformatf("result %0d %s: expected %0d, got %0d",
					results, name, $signed(want), $signed(seen)));
		endfunction

		function void check_word(logic [frna_pkg::TDATA_W-1:0] word);
			hood_mean_t want;
			if (awaited.size() == 0) begin
				fault($sformatf("result word %h with no query outstanding", word));
				return;
			end
			want = awaited.pop_front();
			results++;
			compare_field("neighbor_count", 16'(want.count),
				16'(word[frna_pkg::COUNT_W-1:0]));
			compare_field("avg_pos_x", want.pos_x,
				word[frna_pkg::COUNT_W +: frna_pkg::FIELD_W]);
			compare_field("avg_pos_y", want.pos_y,
				word[frna_pkg::COUNT_W + frna_pkg::FIELD_W +: frna_pkg::FIELD_W]);
			compare_field("avg_vel_x", want.vel_x,
				word[frna_pkg::COUNT_W + 2 * frna_pkg::FIELD_W +: frna_pkg::FIELD_W]);
			compare_field("avg_vel_y", want.vel_y,
				word[frna_pkg::COUNT_W + 3 * frna_pkg::FIELD_W +: frna_pkg::FIELD_W]);
			if (want.count == 0)
				empty_hoods++;
			if (want.count > widest)
				widest = want.count;
		endfunction
	endclass

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	// [5:0] agent_index, [21:6] pos_x, [37:22] pos_y, [53:38] vel_x, [69:54] vel_y, rest 0
	logic [frna_pkg::TDATA_W-1:0]    s_tdata   = '0;
	// [0] op
	logic [0:0]                      s_tuser   = frna_pkg::OP_WRITE;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	// [5:0] neighbor_count, [21:6] avg_pos_x, [37:22] avg_pos_y, [53:38] avg_vel_x,
	// [69:54] avg_vel_y, rest 0
	logic [frna_pkg::TDATA_W-1:0]    m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [frna_pkg::CFG_IDX_W-1:0]  cfg_index = frna_pkg::REG_RADIUS;
	logic [frna_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	neighbor_scoreboard sb = new();

	bit [TABLE_SIZE-1:0] written     = '0;
	int unsigned         items_sent  = 0;
	int unsigned         writes_sent = 0;
	int unsigned         settings    = 0;
	int unsigned         burst_left  = 1;
	logic [15:0]         rx_tick     = '0;
	logic [1:0]          rx_mode     = '0;

	fixed_radius_neighbor_average uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Check each accepted result and stall on a pattern picked anew whenever the low nine bits of rx_tick wrap
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata);
		rx_tick <= rx_tick + 1'b1;
		if (rx_tick[8:0] == '0)
			rx_mode <= 2'($urandom_range(0, 3));
		case (rx_mode)
			2'd0:    m_tready <= 1'b1;
			2'd1:    m_tready <= (rx_tick[1:0] != 2'd0);
			2'd2:    m_tready <= ($urandom_range(0, 9) < 3);
			default: m_tready <= rx_tick[4];
		endcase
	end

	// Offer one word, hold it until taken, then apply burst and gap pacing
	task automatic send_word(input logic op, input logic [frna_pkg::INDEX_W-1:0] idx,
		input logic signed [frna_pkg::FIELD_W-1:0] wx,
		input logic signed [frna_pkg::FIELD_W-1:0] wy,
		input logic signed [frna_pkg::FIELD_W-1:0] ux,
		input logic signed [frna_pkg::FIELD_W-1:0] uy);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{frna_pkg::PAD_W{1'b0}}, uy, ux, wy, wx, idx};
		do @(posedge clk); while (!s_tready);
		sb.note_word(op, idx, wx, wy, ux, uy);
		items_sent++;
		if (op == frna_pkg::OP_WRITE) begin
			written[idx] = 1'b1;
			writes_sent++;
		end
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 9);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic query(input logic [frna_pkg::INDEX_W-1:0] idx);
		send_word(frna_pkg::OP_QUERY, idx, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	// Drop valid, let every outstanding result drain, then give a trailing write time to land
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back while the block is idle
	task automatic configure(input logic [frna_pkg::RADIUS_W-1:0] radius,
		input logic [frna_pkg::AGENTS_W-1:0] agents);
		logic [frna_pkg::CFG_IDX_W-1:0]  idx;
		logic [frna_pkg::CFG_DATA_W-1:0] value;
		wait_idle();
		for (int r = 0; r < 2; r++) begin
			idx   = (r == 0) ? frna_pkg::REG_RADIUS : frna_pkg::REG_AGENT_COUNT;
			value = (r == 0) ? frna_pkg::CFG_DATA_W'(radius) : frna_pkg::CFG_DATA_W'(agents);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= value;
			do @(posedge clk); while (!cfg_ready);
			sb.set_register(idx, value);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Coordinate scattered around a centre, clamped to the Q11.4 range
	function automatic logic signed [frna_pkg::FIELD_W-1:0] near(int centre, int spread);
		int v;
		if (spread >= 32768)
			return 16'($urandom);
		v = centre + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	initial begin
		int                            centre_x, centre_y, spread, reach, span, phase_items;
		logic [frna_pkg::RADIUS_W-1:0] radius;
		logic [frna_pkg::AGENTS_W-1:0] agents;
		logic [frna_pkg::INDEX_W-1:0]  pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: empty walk, so the lone written agent has no neighbours
		send_word(frna_pkg::OP_WRITE, 6'd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
		query(6'd0);

		// Full radius: opposite corners fall outside it, the origin does not
		configure(16'hFFFF, 7'd4);
		send_word(frna_pkg::OP_WRITE, 6'd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
		send_word(frna_pkg::OP_WRITE, 6'd2, 16'sd0, 16'sd0, 16'sd1, -16'sd1);
		send_word(frna_pkg::OP_WRITE, 6'd3, -16'sd1, -16'sd1, -16'sd3, -16'sd5);
		query(6'd0);
		query(6'd1);
		query(6'd2);
		query(6'd3);
		// Alternating bit patterns in the top entries; query one outside the walk
		send_word(frna_pkg::OP_WRITE, 6'd63, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
		send_word(frna_pkg::OP_WRITE, 6'd62, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
		query(6'd63);

		// Distance exactly equal to the radius is not a neighbour
		configure(16'd16, 7'd5);
		send_word(frna_pkg::OP_WRITE, 6'd4, 16'sd16, 16'sd0, 16'sd7, 16'sd7);
		query(6'd2);

		// One step wider takes it in; odd sums show truncation toward zero
		configure(16'd17, 7'd6);
		send_word(frna_pkg::OP_WRITE, 6'd5, 16'sd0, -16'sd16, -16'sd7, 16'sd9);
		query(6'd2);
		query(6'd4);

		// Zero radius finds nothing, as no distance lies strictly inside it
		configure(16'd0, 7'd6);
		query(6'd3);

		// Random phases: clustered or uniform positions, with a radius that is zero, full, random or matched to the spread
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 3))
				0:       spread = 8;
				1:       spread = 64;
				2:       spread = 600;
				default: spread = 32768;
			endcase
			centre_x = int'($urandom_range(0, 65535)) - 32768;
			centre_y = int'($urandom_range(0, 65535)) - 32768;
			case ($urandom_range(0, 5))
				0:       reach = 0;
				1:       reach = 65535;
				2:       reach = $urandom_range(1, 2 * spread);
				3:       reach = $urandom_range(0, 65535);
				default: reach = $urandom_range(spread / 2, 2 * spread);
			endcase
			radius = (reach > 65535) ? 16'hFFFF : 16'(reach);
			case ($urandom_range(0, 5))
				0:       agents = 7'd0;
				1:       agents = 7'd64;
				2:       agents = 7'd127;
				3:       agents = 7'($urandom_range(65, 127));
				default: agents = 7'($urandom_range(1, 64));
			endcase
			configure(radius, agents);

			// Fill the walked part of the table so no unwritten entry is ever read
			span = (agents > TABLE_SIZE) ? TABLE_SIZE : agents;
			for (int i = 0; i < span; i++)
				if (!written[i])
					send_word(frna_pkg::OP_WRITE, 6'(i), near(centre_x, spread),
						near(centre_y, spread), 16'($urandom), 16'($urandom));

			phase_items = $urandom_range(30, 90);
			repeat (phase_items) begin
				if ($urandom_range(0, 99) < 40) begin
					send_word(frna_pkg::OP_WRITE, 6'($urandom), near(centre_x, spread),
						near(centre_y, spread), 16'($urandom), 16'($urandom));
				end else begin
					do pick = 6'($urandom); while (!written[pick]);
					query(pick);
				end
			end
		end

		wait_idle();
		if (sb.awaited.size() != 0)
			sb.fault($sformatf("%0d queries never answered", sb.awaited.size()));
		$display("run: %0d words (%0d table writes) over %0d register settings",
			items_sent, writes_sent, settings);
		$display("run: %0d results checked, %0d with no neighbours, largest count %0d",
			sb.results, sb.empty_hoods, sb.widest);
		if (sb.mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
